### src/lope_pkg.sv
// ----------------------------------------------------------------------------
// lope_pkg: shared constants for the lookback option path engine
// fixed-point constants, register indexes, reset values and the divide table
// ----------------------------------------------------------------------------
package lope_pkg;

    localparam int DEF_MAX_PATHS = 1048576;
    localparam int DEF_MAX_STEPS = 1023;

    // register indexes
    localparam logic [2:0] CFG_START_SPOT  = 3'd0;
    localparam logic [2:0] CFG_STRIKE      = 3'd1;
    localparam logic [2:0] CFG_STEP_DRIFT  = 3'd2;
    localparam logic [2:0] CFG_STEP_DIFF   = 3'd3;
    localparam logic [2:0] CFG_DISCOUNT    = 3'd4;
    localparam logic [2:0] CFG_PATH_COUNT  = 3'd5;
    localparam logic [2:0] CFG_STEPS       = 3'd6;
    localparam logic [2:0] CFG_OPTION_MODE = 3'd7;

    // option modes
    localparam logic [1:0] MODE_FIXED_CALL = 2'd0;
    localparam logic [1:0] MODE_FIXED_PUT  = 2'd1;
    localparam logic [1:0] MODE_FLOAT_CALL = 2'd2;
    localparam logic [1:0] MODE_FLOAT_PUT  = 2'd3;

    // reset values
    localparam logic [31:0] RST_START_SPOT = 32'd6553600;
    localparam logic [31:0] RST_STRIKE     = 32'd6553600;
    localparam logic [20:0] RST_PATH_COUNT = 21'd1024;
    localparam logic [9:0]  RST_STEPS      = 10'd100;

    // fixed point
    localparam logic [31:0] Q30_ONE   = 32'd1073741824;
    localparam logic [36:0] LN2_Q30   = 37'd744261118;
    localparam logic [31:0] RECIP_LN2 = 32'd1549082004;   // floor(2^60 / ln2 in q.30)
    localparam logic signed [48:0] X_LIMIT = 49'sd25769803776;
    localparam logic [6:0]  K_BIAS    = 7'd35;
    localparam logic [36:0] X_BIAS    = 37'd26049139130;   // 35 * ln2 in q.30
    localparam logic [51:0] SUM_MAX   = {52{1'b1}};

    typedef struct packed {
        logic [31:0] mult;
        logic [5:0]  sh;
        logic        bypass;
    } t_recip;

    // floor(v / n) = (v * mult) >> sh, exact for v < 2^31
    function automatic t_recip recip_of(input logic [3:0] n);
        t_recip r;
        r.bypass = 1'b0;
        r.mult   = 32'd0;
        r.sh     = 6'd32;
        case (n)
            4'd1: r.bypass = 1'b1;
            4'd2: r.mult = 32'h8000_0000;
            4'd3: begin r.mult = 32'd2863311531; r.sh = 6'd33; end
            4'd4: r.mult = 32'h4000_0000;
            4'd5: begin r.mult = 32'd3435973837; r.sh = 6'd34; end
            4'd6: begin r.mult = 32'd2863311531; r.sh = 6'd34; end
            4'd7: begin r.mult = 32'd2454267027; r.sh = 6'd34; end
            4'd8: r.mult = 32'h2000_0000;
            default: r.bypass = 1'b1;
        endcase
        return r;
    endfunction

endpackage

### src/lope_mul.sv
// ----------------------------------------------------------------------------
// lope_mul: shared multiplier
// unsigned 32 x 32 multiply with a registered 64 bit product
// ----------------------------------------------------------------------------
module lope_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;

endmodule

### src/lookback_option_path_engine_core.sv
// ----------------------------------------------------------------------------
// lookback_option_path_engine_core: monte carlo lookback option path engine
// steps a gbm spot per gaussian item, tracks path extremes, emits payoffs
// ----------------------------------------------------------------------------
// One item is one gaussian sample for one time step. A small sequencer drives
// one shared registered 32x32 multiplier: diffusion times sample, a range
// reduction by ln2 (reciprocal multiply, back multiply, one correcting
// subtract), an 8 term horner exponential (two multiplies per term, one when
// the divisor is one) and the spot multiply.
// A step that closes a path adds a payoff step, and the last path of a batch
// then takes the multiply and sum steps of the price
// (hi and lo halves of the sum times the discount). Ready is low while an
// item is at work. A finished result sits in the output register while the
// next item is taken; the block stalls only if a second result is ready
// before the first is taken. Configuration writes are always taken.
module lookback_option_path_engine_core #(
    parameter int MAX_PATHS = lope_pkg::DEF_MAX_PATHS,
    parameter int MAX_STEPS = lope_pkg::DEF_MAX_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // sample items
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_gauss_sample,
    // result items
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_path_payoff,
    output logic [31:0]        o_option_price,
    output logic               o_final_path
);

    localparam int PW = $clog2(MAX_PATHS + 1);
    localparam int SW = $clog2(MAX_STEPS + 1);

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000000000000001,
        S_TMUL   = 16'b0000000000000010,
        S_XCALC  = 16'b0000000000000100,
        S_DIV    = 16'b0000000000001000,
        S_QMUL   = 16'b0000000000010000,
        S_QFIX   = 16'b0000000000100000,
        S_EMUL   = 16'b0000000001000000,
        S_EDIV   = 16'b0000000010000000,
        S_EADD   = 16'b0000000100000000,
        S_SMUL   = 16'b0000001000000000,
        S_SSHIFT = 16'b0000010000000000,
        S_PAY    = 16'b0000100000000000,
        S_PLO    = 16'b0001000000000000,
        S_PHI    = 16'b0010000000000000,
        S_PSUM   = 16'b0100000000000000,
        S_EMIT   = 16'b1000000000000000
    } t_state;

    // configuration registers
    logic [31:0] r_start_spot, r_strike, r_discount;
    logic [31:0] r_drift;
    logic [30:0] r_diff;
    logic [20:0] r_path_count;
    logic [9:0]  r_steps;
    logic [1:0]  r_mode;

    // path and batch state
    logic [31:0]   r_spot, r_max, r_min;
    logic [SW-1:0] r_step_idx;
    logic [PW-1:0] r_paths_done;
    logic [51:0]   r_sum;

    // sequencer and datapath
    t_state      r_state;
    logic [15:0] r_zmag;
    logic        r_zneg;
    logic [36:0] r_rem;
    logic [6:0]  r_q;
    logic signed [7:0] r_k;
    logic [31:0] r_acc;
    logic [3:0]  r_n;
    logic [5:0]  r_sh;
    logic [31:0] r_lo_part;
    logic [31:0] r_payoff, r_price;
    logic        r_final;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_payoff, r_out_price;
    logic        r_out_final;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    lope_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    lope_pkg::t_recip cur_recip;
    assign cur_recip = lope_pkg::recip_of(r_n);

    // operand select by sequencer step
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_TMUL: begin
                mul_a = {1'b0, r_diff};
                mul_b = {16'd0, r_zmag};
            end
            S_DIV: begin
                // quotient estimate: (x_biased >> 4) * 2^60 / ln2 >> 56
                mul_a = r_rem[35:4];
                mul_b = lope_pkg::RECIP_LN2;
            end
            S_QMUL: begin
                mul_a = {25'd0, mul_p[62:56]};
                mul_b = 32'(lope_pkg::LN2_Q30);
            end
            S_EMUL: begin
                mul_a = r_acc;
                mul_b = {2'b00, r_rem[29:0]};
            end
            S_EDIV: begin
                mul_a = mul_p[61:30];
                mul_b = cur_recip.mult;
            end
            S_SMUL: begin
                mul_a = r_spot;
                mul_b = r_acc;
            end
            S_PLO: begin
                mul_a = r_sum[31:0];
                mul_b = r_discount;
            end
            S_PHI: begin
                mul_a = {12'd0, r_sum[51:32]};
                mul_b = r_discount;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // effective step and path counts
    logic [SW-1:0] steps_eff;
    logic [PW-1:0] paths_eff;
    always_comb begin
        if (r_steps == 10'd0) begin
            steps_eff = SW'(1);
        end else if (32'(r_steps) > 32'(MAX_STEPS)) begin
            steps_eff = SW'(MAX_STEPS);
        end else begin
            steps_eff = SW'(r_steps);
        end
        if (r_path_count == 21'd0) begin
            paths_eff = PW'(1);
        end else if (32'(r_path_count) > 32'(MAX_PATHS)) begin
            paths_eff = PW'(MAX_PATHS);
        end else begin
            paths_eff = PW'(r_path_count);
        end
    end

    // log-return x = drift + floor(diff * z / 2^12), clamped, then biased
    logic signed [48:0] t_prod, x_raw, x_clamp;
    logic [36:0]        x_biased;
    always_comb begin
        t_prod = r_zneg ? -$signed({2'b00, mul_p[46:0]}) : $signed({2'b00, mul_p[46:0]});
        x_raw  = $signed({{17{r_drift[31]}}, r_drift}) + (t_prod >>> 12);
        if (x_raw > lope_pkg::X_LIMIT) begin
            x_clamp = lope_pkg::X_LIMIT;
        end else if (x_raw < -lope_pkg::X_LIMIT) begin
            x_clamp = -lope_pkg::X_LIMIT;
        end else begin
            x_clamp = x_raw;
        end
        x_biased = 37'(x_clamp) + lope_pkg::X_BIAS;
    end

    // range reduction: the estimate is low by at most one
    logic [37:0] red_r0, red_r1;
    logic [6:0]  q_fix;
    always_comb begin
        red_r0 = {1'b0, r_rem} - {1'b0, mul_p[36:0]};
        red_r1 = red_r0 - {1'b0, lope_pkg::LN2_Q30};
        q_fix  = red_r1[37] ? r_q : r_q + 7'd1;
    end

    // spot scaling by 2^k with saturation
    logic [31:0] spot_new;
    logic [6:0]  rsh;
    logic [2:0]  lsh;
    logic [62:0] sprod;
    logic [62:0] shr;
    always_comb begin
        sprod    = mul_p[62:0];
        rsh      = 7'(8'sd30 - r_k);
        lsh      = 3'(r_k - 8'sd30);
        shr      = sprod >> rsh[5:0];
        spot_new = 32'd0;
        if (r_k <= 8'sd30) begin
            if (rsh >= 7'd64) begin
                spot_new = 32'd0;
            end else if (shr > 63'h0_FFFF_FFFF) begin
                spot_new = 32'hFFFF_FFFF;
            end else begin
                spot_new = shr[31:0];
            end
        end else begin
            if (sprod > (63'h0_FFFF_FFFF >> lsh)) begin
                spot_new = 32'hFFFF_FFFF;
            end else begin
                spot_new = 32'(sprod << lsh);
            end
        end
    end

    // lookback payoff
    logic [31:0] payoff;
    logic [52:0] sum_add;
    always_comb begin
        case (r_mode)
            lope_pkg::MODE_FIXED_CALL: payoff = (r_max > r_strike) ? r_max - r_strike : 32'd0;
            lope_pkg::MODE_FIXED_PUT:  payoff = (r_strike > r_min) ? r_strike - r_min : 32'd0;
            lope_pkg::MODE_FLOAT_CALL: payoff = r_spot - r_min;
            default:                   payoff = r_max - r_spot;
        endcase
        sum_add = {1'b0, r_sum} + {21'd0, payoff};
    end

    logic [52:0] price_full;
    assign price_full = mul_p[52:0] + {21'd0, r_lo_part};

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_spot <= lope_pkg::RST_START_SPOT;
            r_strike     <= lope_pkg::RST_STRIKE;
            r_drift      <= 32'd0;
            r_diff       <= 31'd0;
            r_discount   <= 32'd0;
            r_path_count <= lope_pkg::RST_PATH_COUNT;
            r_steps      <= lope_pkg::RST_STEPS;
            r_mode       <= lope_pkg::MODE_FIXED_CALL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lope_pkg::CFG_START_SPOT: r_start_spot <= i_cfg_data;
                lope_pkg::CFG_STRIKE:     r_strike     <= i_cfg_data;
                lope_pkg::CFG_STEP_DRIFT: r_drift      <= i_cfg_data;
                lope_pkg::CFG_STEP_DIFF:  r_diff       <= i_cfg_data[30:0];
                lope_pkg::CFG_DISCOUNT:   r_discount   <= i_cfg_data;
                lope_pkg::CFG_PATH_COUNT: r_path_count <= i_cfg_data[20:0];
                lope_pkg::CFG_STEPS:      r_steps      <= i_cfg_data[9:0];
                default:                  r_mode       <= i_cfg_data[1:0];
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_spot       <= lope_pkg::RST_START_SPOT;
            r_max        <= lope_pkg::RST_START_SPOT;
            r_min        <= lope_pkg::RST_START_SPOT;
            r_step_idx   <= '0;
            r_paths_done <= '0;
            r_sum        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // the emit step reloads the register itself when it is taken
            if (r_out_valid && i_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_zneg  <= i_gauss_sample[15];
                        r_zmag  <= i_gauss_sample[15] ? 16'(-i_gauss_sample)
                                                      : 16'(i_gauss_sample);
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: r_state <= S_XCALC;
                S_XCALC: begin
                    r_rem   <= x_biased;
                    r_state <= S_DIV;
                end
                S_DIV: r_state <= S_QMUL;
                S_QMUL: begin
                    r_q     <= mul_p[62:56];
                    r_state <= S_QFIX;
                end
                S_QFIX: begin
                    r_rem   <= red_r1[37] ? red_r0[36:0] : red_r1[36:0];
                    r_k     <= $signed({1'b0, q_fix}) - $signed({1'b0, lope_pkg::K_BIAS});
                    r_acc   <= lope_pkg::Q30_ONE;
                    r_n     <= 4'd8;
                    r_state <= S_EMUL;
                end
                S_EMUL: r_state <= S_EDIV;
                S_EDIV: begin
                    if (cur_recip.bypass) begin
                        r_acc   <= lope_pkg::Q30_ONE + mul_p[61:30];
                        r_state <= S_SMUL;
                    end else begin
                        r_sh    <= cur_recip.sh;
                        r_state <= S_EADD;
                    end
                end
                S_EADD: begin
                    r_acc   <= lope_pkg::Q30_ONE + 32'(mul_p >> r_sh);
                    r_n     <= r_n - 4'd1;
                    r_state <= S_EMUL;
                end
                S_SMUL: r_state <= S_SSHIFT;
                S_SSHIFT: begin
                    r_spot <= spot_new;
                    if (spot_new > r_max) r_max <= spot_new;
                    if (spot_new < r_min) r_min <= spot_new;
                    if ((r_step_idx + SW'(1)) < steps_eff) begin
                        r_step_idx <= r_step_idx + SW'(1);
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_PAY;
                    end
                end
                S_PAY: begin
                    r_payoff   <= payoff;
                    r_sum      <= sum_add[52] ? lope_pkg::SUM_MAX : sum_add[51:0];
                    r_spot     <= r_start_spot;
                    r_max      <= r_start_spot;
                    r_min      <= r_start_spot;
                    r_step_idx <= '0;
                    if ((r_paths_done + PW'(1)) >= paths_eff) begin
                        r_state <= S_PLO;
                    end else begin
                        r_paths_done <= r_paths_done + PW'(1);
                        r_price      <= 32'd0;
                        r_final      <= 1'b0;
                        r_state      <= S_EMIT;
                    end
                end
                S_PLO: r_state <= S_PHI;
                S_PHI: begin
                    r_lo_part <= mul_p[63:32];
                    r_state   <= S_PSUM;
                end
                S_PSUM: begin
                    r_price      <= (price_full > 53'h0_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                  : price_full[31:0];
                    r_final      <= 1'b1;
                    r_sum        <= '0;
                    r_paths_done <= '0;
                    r_state      <= S_EMIT;
                end
                S_EMIT: begin
                    // wait only while an older result is still held
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_payoff <= r_payoff;
                        r_out_price  <= r_price;
                        r_out_final  <= r_final;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_path_payoff  = r_out_payoff;
    assign o_option_price = r_out_price;
    assign o_final_path   = r_out_final;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after an item was accepted");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SSHIFT) |-> (r_k >= -8'sd35 && r_k <= 8'sd35))
        else $error("exponent out of range");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result loaded outside the emit step");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PSUM) |=> (r_sum == '0 && r_paths_done == '0))
        else $error("batch state not cleared after price");
`endif

endmodule
